// File: rtl/vrbs_pkg.sv
// Shared types and codes for the variable-length record byte stack.
package vrbs_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STATUS_W = 3;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_BEGIN = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BYTE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP        = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CHECK_ROOM = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STS_STRAY = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BUSY  = 3'd4;

  // One input transaction
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LEN_W-1:0]    record_length;
    logic [7:0]          data_byte;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                last;
    logic                is_empty;
  } result_t;

endpackage

// File: rtl/variable_record_byte_stack_top.sv
// Variable-length record byte stack: LIFO of length-prefixed records in one byte RAM.
//
//  channel  | ports                                | handshake
//  ---------+--------------------------------------+----------------------------------
//  command  | start_i, busy_o, in_item_i           | taken when start_i & !busy_o
//  result   | result_valid_o, result_o             | one-cycle strobe, no back-pressure
//
// push_byte, clear, check_room and rejected commands never raise busy: one per cycle.
// push_begin writes its header one byte a cycle and stays busy until the header is in.
// pop/peek: a header read (ST_RDHDR), a sizing step (ST_CALC), then streaming of n bytes
// (ST_STREAM); all reads go through the single RAM read port.
// Reset empties the stack at once; RAM contents are not cleared.
// Results appear in the cycle after the work that makes them and cannot be stalled.
module variable_record_byte_stack_top
  import vrbs_pkg::*;
#(
  parameter int unsigned STACK_BYTES  = 1024,
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned MAX_RECORD   = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  in_item_t in_item_i,
  output logic     result_valid_o,
  output result_t  result_o
);

  localparam int unsigned AW    = (STACK_BYTES > 1) ? $clog2(STACK_BYTES) : 1;
  localparam int unsigned OFF_W = $clog2(STACK_BYTES + 1);
  localparam int unsigned HDR_W = 8 * HEADER_BYTES;
  localparam int unsigned SUM_W = ((HDR_W > OFF_W) ? HDR_W : OFF_W) + 2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_HDR    = 5'b00010,
    ST_RDHDR  = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_STREAM = 5'b10000
  } state_e;

  // Byte RAM
  logic [7:0]    mem [STACK_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rdata_q;

  // Control and pointer state
  state_e             state_q, state_d;
  logic [OFF_W-1:0]   top_q, top_d;
  logic [OFF_W-1:0]   wp_q, wp_d;
  logic [LEN_W-1:0]   pend_q, pend_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   n_q, n_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               is_pop_q, is_pop_d;
  logic [HDR_W-1:0]   stored_q, stored_d;
  logic [OFF_W-1:0]   base_q, base_d;
  logic               rvalid_q, rvalid_d;
  result_t            res_q, res_d;

  // Helpers
  logic               accept;
  logic               fits;
  logic [OFF_W:0]     need;
  logic [OFF_W:0]     sum_rd;
  logic [LEN_W-1:0]   hdr_cnt_m1;
  logic [LEN_W-1:0]   n_min;
  logic [SUM_W-1:0]   new_top_wide;
  logic               emit;
  logic [STATUS_W-1:0] emit_status;
  logic [7:0]         emit_byte;
  logic               emit_valid;
  logic               emit_last;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Room check for push_begin and check_room
  assign need = (OFF_W+1)'(in_item_i.record_length) + (OFF_W+1)'(HEADER_BYTES);
  assign fits = (in_item_i.record_length <= LEN_W'(MAX_RECORD)) &&
                ({1'b0, top_q} >= need);

  assign hdr_cnt_m1 = cnt_q - LEN_W'(1);

  // Copy length: min(requested, stored), capped at MAX_RECORD
  always_comb begin
    if (stored_q < HDR_W'(len_q)) begin
      n_min = stored_q[LEN_W-1:0];
    end else begin
      n_min = len_q;
    end
    if (stored_q < HDR_W'(len_q) && (stored_q > HDR_W'(MAX_RECORD))) begin
      n_min = LEN_W'(MAX_RECORD);
    end else if (n_min > LEN_W'(MAX_RECORD)) begin
      n_min = LEN_W'(MAX_RECORD);
    end
  end

  // Top after a pop, saturated at the empty mark
  assign new_top_wide = SUM_W'(top_q) + SUM_W'(HEADER_BYTES) + SUM_W'(stored_q);

  // Main sequencer
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    wp_d        = wp_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    len_d       = len_q;
    is_pop_d    = is_pop_q;
    stored_d    = stored_q;
    base_d      = base_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = wp_q[AW-1:0];
    mem_wdata   = in_item_i.data_byte;
    mem_raddr   = top_q[AW-1:0];
    emit        = 1'b0;
    emit_status = STS_OK;
    emit_byte   = 8'h00;
    emit_valid  = 1'b0;
    emit_last   = 1'b1;
    sum_rd      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (in_item_i.action == ACT_PUSH_BYTE) begin
            if (pend_q == '0) begin
              emit_status = STS_STRAY;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = wp_q[AW-1:0];
              wp_d      = wp_q + OFF_W'(1);
              pend_d    = pend_q - LEN_W'(1);
            end
          end else if (pend_q != '0) begin
            emit_status = STS_BUSY;
          end else begin
            case (in_item_i.action)
              ACT_PUSH_BEGIN: begin
                if (!fits) begin
                  emit_status = STS_FULL;
                end else begin
                  // Result follows once the header is in
                  emit    = 1'b0;
                  wp_d    = top_q - OFF_W'(in_item_i.record_length);
                  top_d   = top_q - OFF_W'(in_item_i.record_length)
                            - OFF_W'(HEADER_BYTES);
                  pend_d  = in_item_i.record_length;
                  len_d   = in_item_i.record_length;
                  cnt_d   = '0;
                  state_d = ST_HDR;
                end
              end
              ACT_POP, ACT_PEEK: begin
                if (top_q >= OFF_W'(STACK_BYTES)) begin
                  emit_status = STS_EMPTY;
                end else begin
                  emit     = 1'b0;
                  len_d    = in_item_i.record_length;
                  is_pop_d = (in_item_i.action == ACT_POP);
                  stored_d = '0;
                  cnt_d    = '0;
                  state_d  = ST_RDHDR;
                end
              end
              ACT_CLEAR: begin
                top_d = OFF_W'(STACK_BYTES);
              end
              ACT_CHECK_ROOM: begin
                emit_status = fits ? STS_OK : STS_FULL;
              end
              default: begin
                emit_status = STS_OK;
              end
            endcase
          end
        end
      end

      // Header write, little-endian, one byte a cycle
      ST_HDR: begin
        sum_rd    = {1'b0, top_q} + (OFF_W+1)'(cnt_q);
        mem_we    = 1'b1;
        mem_waddr = sum_rd[AW-1:0];
        mem_wdata = (cnt_q == '0) ? 8'(len_q) : 8'h00;
        cnt_d     = cnt_q + LEN_W'(1);
        if (cnt_q == LEN_W'(HEADER_BYTES - 1)) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      // Header read: issue one address a cycle, collect each byte in the cycle after
      ST_RDHDR: begin
        sum_rd = {1'b0, top_q} + (OFF_W+1)'(cnt_q);
        if (cnt_q < LEN_W'(HEADER_BYTES)) begin
          mem_re    = 1'b1;
          mem_raddr = sum_rd[AW-1:0];
        end
        if (cnt_q != '0) begin
          stored_d = stored_q | (HDR_W'(rdata_q) << (8 * hdr_cnt_m1));
        end
        cnt_d = cnt_q + LEN_W'(1);
        if (cnt_q == LEN_W'(HEADER_BYTES)) begin
          state_d = ST_CALC;
        end
      end

      // Size the copy and free the record on pop
      ST_CALC: begin
        n_d    = n_min;
        base_d = top_q + OFF_W'(HEADER_BYTES);
        cnt_d  = '0;
        if (is_pop_q) begin
          if (new_top_wide > SUM_W'(STACK_BYTES)) begin
            top_d = OFF_W'(STACK_BYTES);
          end else begin
            top_d = new_top_wide[OFF_W-1:0];
          end
        end
        if (n_min == '0) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_STREAM;
        end
      end

      // Byte stream: read k, emit k-1
      ST_STREAM: begin
        sum_rd = {1'b0, base_q} + (OFF_W+1)'(cnt_q);
        if (cnt_q < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = sum_rd[AW-1:0];
        end
        if (cnt_q != '0) begin
          emit       = 1'b1;
          emit_byte  = rdata_q;
          emit_valid = 1'b1;
          emit_last  = (cnt_q == n_q);
        end
        cnt_d = cnt_q + LEN_W'(1);
        if (cnt_q == n_q) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register; emptiness reflects the state after this step
  always_comb begin
    rvalid_d         = emit;
    res_d.status     = emit_status;
    res_d.out_byte   = emit_byte;
    res_d.byte_valid = emit_valid;
    res_d.last       = emit_last;
    res_d.is_empty   = (top_d >= OFF_W'(STACK_BYTES));
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      top_q    <= OFF_W'(STACK_BYTES);
      wp_q     <= '0;
      pend_q   <= '0;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      wp_q     <= wp_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    len_q    <= len_d;
    is_pop_q <= is_pop_d;
    stored_q <= stored_d;
    base_q   <= base_d;
    res_q    <= res_d;
  end

  // RAM write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // RAM read port, registered data
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

endmodule
